// File: rtl/nor_flash_erase_program_sequencer_core_assert.svh
// Assertion macros used by the sequencer checker.
`ifndef NOR_FLASH_ERASE_PROGRAM_SEQUENCER_CORE_ASSERT_SVH
`define NOR_FLASH_ERASE_PROGRAM_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NFEPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NFEPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/nfeps_pkg.sv
// Types, constants and register codes for the flash erase/program sequencer.
package nfeps_pkg;

	localparam int PAGE_BYTES   = 256;
	localparam int PAGE_LSB     = $clog2(PAGE_BYTES);
	localparam int ERASE_SLOTS  = 4;
	localparam int SLOT_W       = 2;
	localparam int SIZE_CODE_W  = 5;
	localparam int DLEN_W       = 9;
	localparam int OQ_DEPTH     = 4;
	localparam int CFG_IDX_W    = 2;

	localparam logic [7:0] OP_WREN = 8'h06;
	localparam logic [7:0] OP_RDSR = 8'h05;

	localparam int ST_WIP_BIT = 0;
	localparam int ST_WEL_BIT = 1;

	localparam logic [1:0] MODE_ERASE   = 2'd0;
	localparam logic [1:0] MODE_PROGRAM = 2'd1;
	localparam logic [1:0] MODE_STATUS  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_SIZES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_OPCODES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROG_OPCODE   = 2'd2;

	localparam logic [19:0] ERASE_SIZES_RST   = 20'd16876;
	localparam logic [31:0] ERASE_OPCODES_RST = 32'h00D8_5220;
	localparam logic [7:0]  PROG_OPCODE_RST   = 8'h02;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] address;
		logic [31:0] length;
		logic [7:0]  status;
	} in_t;

	typedef struct packed {
		logic [7:0]        opcode;
		logic [31:0]       cmd_address;
		logic              has_address;
		logic [DLEN_W-1:0] data_length;
		logic [31:0]       buffer_offset;
		logic              expects_status;
		logic              done_res;
		logic              error;
		logic              last;
	} out_t;

endpackage

// File: rtl/nor_flash_erase_program_sequencer_core.sv
// Top level of the SPI NOR flash erase/program command sequencer.
//
// Input channel (in_valid/in_ready/in_data): a start of an erase or program
// request, or a status byte read back from the flash. Each transfer yields
// zero, one or two command results on the output channel
// (out_valid/out_ready/out_data); the last result of a transfer has last set.
// Results of a transfer are written into the result queue when it is taken.
// Throughput: one input transfer per cycle while the four-entry result queue
// has room for two results; the output side drains one result per cycle while
// out_ready is high. When the receiver stalls, results wait in the queue and
// in_ready drops once fewer than two entries are free.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 erase size
// codes, 1 erase opcodes, 2 program opcode) at the clock edge; write only
// while idle.
// Reset (arst_n low): queue empty, sequencer idle, registers at defaults.
module nor_flash_erase_program_sequencer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  nfeps_pkg::in_t                     in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output nfeps_pkg::out_t                    out_data,
	input  logic                               cfg_we,
	input  logic [nfeps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                        cfg_data
);
	import nfeps_pkg::*;

	logic [19:0] erase_size_codes_q;
	logic [31:0] erase_opcodes_q;
	logic [7:0]  program_opcode_q;

	logic        accept;
	logic [1:0]  res_cnt;
	logic [1:0]  push_cnt;
	out_t        res0;
	out_t        res1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_size_codes_q <= ERASE_SIZES_RST;
			erase_opcodes_q <= ERASE_OPCODES_RST;
			program_opcode_q <= PROG_OPCODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ERASE_SIZES:   erase_size_codes_q <= cfg_data[19:0];
				CFG_ERASE_OPCODES: erase_opcodes_q <= cfg_data;
				CFG_PROG_OPCODE:   program_opcode_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;
	assign push_cnt = accept ? res_cnt : 2'd0;

	nfeps_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.item             (in_data),
		.erase_size_codes (erase_size_codes_q),
		.erase_opcodes    (erase_opcodes_q),
		.program_opcode   (program_opcode_q),
		.res_cnt          (res_cnt),
		.res0             (res0),
		.res1             (res1)
	);

	nfeps_oq u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (res0),
		.push1     (res1),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: rtl/nfeps_seq.sv
// Command sequencing state and per-transfer result decision.
module nfeps_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  nfeps_pkg::in_t      item,
	input  logic [19:0]         erase_size_codes,
	input  logic [31:0]         erase_opcodes,
	input  logic [7:0]          program_opcode,
	output logic [1:0]          res_cnt,
	output nfeps_pkg::out_t     res0,
	output nfeps_pkg::out_t     res1
);
	import nfeps_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WEL  = 2'd1,
		PH_WIP  = 2'd2
	} phase_t;

	phase_t             phase_q, phase_d;
	logic               prog_q, prog_d;
	logic [31:0]        addr_q, addr_d;
	logic [31:0]        rem_q, rem_d;
	logic [SLOT_W-1:0]  slot_q, slot_d;
	logic [31:0]        src_q, src_d;

	logic               idle;
	logic               chunk;
	logic               pick_ok;
	logic [SLOT_W-1:0]  pick_slot;
	logic [SIZE_CODE_W-1:0] cand_code;
	logic [31:0]        cand_size;
	logic [SIZE_CODE_W-1:0] wel_code;
	logic [31:0]        chunk_size;
	logic [31:0]        page_n;
	out_t               rdsr_res;

	assign idle = (phase_q != PH_WEL) && (phase_q != PH_WIP);
	assign wel_code = erase_size_codes[SIZE_CODE_W*slot_q +: SIZE_CODE_W];
	assign chunk_size = 32'd1 << wel_code;
	assign page_n = (rem_q < 32'(PAGE_BYTES)) ? rem_q : 32'(PAGE_BYTES);

	always_comb begin
		rdsr_res = '0;
		rdsr_res.opcode = OP_RDSR;
		rdsr_res.expects_status = 1'b1;
		rdsr_res.last = 1'b1;
	end

	always_comb begin
		phase_d = phase_q;
		prog_d = prog_q;
		addr_d = addr_q;
		rem_d = rem_q;
		slot_d = slot_q;
		src_d = src_q;
		res_cnt = 2'd0;
		res0 = '0;
		res1 = '0;
		chunk = 1'b0;
		pick_ok = 1'b0;
		pick_slot = '0;
		cand_code = '0;
		cand_size = '0;
		case (item.mode)
			MODE_ERASE, MODE_PROGRAM: begin
				if (idle) begin
					prog_d = (item.mode == MODE_PROGRAM);
					addr_d = item.address;
					rem_d = item.length;
					src_d = '0;
					slot_d = '0;
					if (prog_d && (item.address[PAGE_LSB-1:0] != '0)) begin
						phase_d = PH_IDLE;
						res_cnt = 2'd1;
						res0.done_res = 1'b1;
						res0.error = 1'b1;
						res0.last = 1'b1;
					end else begin
						chunk = 1'b1;
					end
				end
			end
			MODE_STATUS: begin
				case (phase_q)
					PH_WEL: begin
						if (!item.status[ST_WEL_BIT]) begin
							res_cnt = 2'd1;
							res0 = rdsr_res;
						end else begin
							res0.has_address = 1'b1;
							res0.cmd_address = addr_q;
							if (prog_q) begin
								res0.opcode = program_opcode;
								res0.data_length = page_n[DLEN_W-1:0];
								res0.buffer_offset = src_q;
								addr_d = addr_q + 32'(PAGE_BYTES);
								src_d = src_q + 32'(PAGE_BYTES);
								rem_d = rem_q - page_n;
							end else begin
								res0.opcode = erase_opcodes[8*slot_q +: 8];
								addr_d = addr_q + chunk_size;
								rem_d = (rem_q > chunk_size) ? rem_q - chunk_size : '0;
							end
							phase_d = PH_WIP;
							res1 = rdsr_res;
							res_cnt = 2'd2;
						end
					end
					PH_WIP: begin
						if (item.status[ST_WIP_BIT]) begin
							res_cnt = 2'd1;
							res0 = rdsr_res;
						end else if (rem_q == '0) begin
							phase_d = PH_IDLE;
							res_cnt = 2'd1;
							res0.done_res = 1'b1;
							res0.last = 1'b1;
						end else begin
							chunk = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		if (chunk) begin
			for (int i = 0; i < ERASE_SLOTS; i++) begin
				cand_code = erase_size_codes[SIZE_CODE_W*i +: SIZE_CODE_W];
				cand_size = 32'd1 << cand_code;
				if ((cand_code != '0) && (rem_d >= cand_size)
						&& ((addr_d & (cand_size - 32'd1)) == '0)) begin
					pick_ok = 1'b1;
					pick_slot = SLOT_W'(i);
				end
			end
			if (prog_d ? (rem_d == '0) : !pick_ok) begin
				phase_d = PH_IDLE;
				res_cnt = 2'd1;
				res0.done_res = 1'b1;
				res0.error = !prog_d;
				res0.last = 1'b1;
			end else begin
				if (!prog_d) begin
					slot_d = pick_slot;
				end
				phase_d = PH_WEL;
				res0.opcode = OP_WREN;
				res1 = rdsr_res;
				res_cnt = 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			prog_q <= 1'b0;
			addr_q <= '0;
			rem_q <= '0;
			slot_q <= '0;
			src_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			prog_q <= prog_d;
			addr_q <= addr_d;
			rem_q <= rem_d;
			slot_q <= slot_d;
			src_q <= src_d;
		end
	end

endmodule

// File: rtl/nfeps_oq.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
module nfeps_oq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_cnt,
	input  nfeps_pkg::out_t push0,
	input  nfeps_pkg::out_t push1,
	output logic            space,
	output logic            out_valid,
	input  logic            out_ready,
	output nfeps_pkg::out_t out_data
);
	import nfeps_pkg::*;

	localparam int PTR_W = $clog2(OQ_DEPTH);
	localparam int CNT_W = $clog2(OQ_DEPTH + 1);

	out_t             mem_q [OQ_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] tail;
	logic             pop;

	assign tail = head_q + count_q[PTR_W-1:0];
	assign pop = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_data = mem_q[head_q];
	assign space = (count_q <= CNT_W'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[tail] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[tail + PTR_W'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

endmodule

// File: rtl/nfeps_checker.sv
// Port-level checks for the sequencer, bound to the top level.
`include "nor_flash_erase_program_sequencer_core_assert.svh"

module nfeps_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input nfeps_pkg::out_t out_data
);
	import nfeps_pkg::*;

	`NFEPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_data), "output changed while stalled")

	`NFEPS_ASSERT_NOW(a_done_clean, out_valid && out_data.done_res,
		out_data.opcode == 8'h00 && !out_data.expects_status && out_data.last,
		"done result carries a command")

	`NFEPS_ASSERT_NOW(a_poll_shape, out_valid && out_data.expects_status,
		out_data.opcode == OP_RDSR && out_data.last && !out_data.has_address,
		"status poll malformed")

	`NFEPS_ASSERT_NOW(a_err_done, out_valid && out_data.error,
		out_data.done_res, "error without done")

	`NFEPS_ASSERT_NOW(a_addr_cmd_first, out_valid && out_data.has_address,
		!out_data.last && !out_data.done_res, "addressed command ends a transfer")

endmodule

bind nor_flash_erase_program_sequencer_core nfeps_checker u_nfeps_checker (.*);
